@@ hw/rtl/per_pkg.sv @@
package per_pkg;

    // Default storage sizes
    localparam int DEF_RING_SLOTS      = 32;
    localparam int DEF_MAX_EVENT_BYTES = 64;

    // Fixed field widths
    localparam int OP_W        = 3;
    localparam int TYPE_W      = 8;
    localparam int LEN_IN_W    = 8;
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 6;
    localparam int SEQ_W       = 8;
    localparam int SEL_W       = 5;
    localparam int KIND_W      = 3;
    localparam int LEN_OUT_W   = 7;
    localparam int SLOT_OUT_W  = 5;
    localparam int COUNT_OUT_W = 6;
    localparam int BUDGET_W    = 11;

    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 11'd255;
    localparam int                  HEADER_BYTES = 3;
    localparam logic [SEQ_W-1:0]    FIRST_SEQ    = 8'd1;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 3'd0,
        OP_WRITE   = 3'd1,
        OP_ACK     = 3'd2,
        OP_POLL    = 3'd3,
        OP_READ    = 3'd4
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQ_REPLY    = 3'd0,
        KIND_WRITE_DONE   = 3'd1,
        KIND_ACK_REPLY    = 3'd2,
        KIND_POLL_ENTRY   = 3'd3,
        KIND_POLL_SUMMARY = 3'd4,
        KIND_READ_BYTE    = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ENQ_SCAN,
        ST_ACK_SCAN,
        ST_ACK_META,
        ST_POLL_SCAN,
        ST_POLL_META,
        ST_READ_WAIT,
        ST_EMIT_ENTRY,
        ST_EMIT_FINAL
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic  capture;      // latch the item, clear scan, result and poll totals
        logic  scan_step;    // advance the slot scan
        logic  meta_rd;      // read the header of the scanned slot
        logic  enq_commit;   // claim the scanned slot
        logic  ack_commit;   // free the scanned slot
        logic  entry_commit; // take the scanned slot into the poll reply
        logic  data_wr;      // write the data byte
        logic  data_rd;      // read the data byte
        logic  byte_take;    // hold the byte just read
        logic  out_load;     // load the result register
        kind_t out_kind;
    } per_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            slot_used;
        logic            scan_last;
        logic            seq_match;
        logic            entry_fits;
        logic            out_free;
    } per_status_t;

endpackage

@@ hw/rtl/per_ram.sv @@
module per_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/per_ctrl.sv @@
module per_ctrl
    import per_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  per_status_t status,
    output per_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    kind_t  final_kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Closing result of each operation
    always_comb
    begin
        case (status.op)
            OP_ENQUEUE: final_kind = KIND_ENQ_REPLY;
            OP_ACK:     final_kind = KIND_ACK_REPLY;
            OP_POLL:    final_kind = KIND_POLL_SUMMARY;
            OP_READ:    final_kind = KIND_READ_BYTE;
            default:    final_kind = KIND_WRITE_DONE;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (status.op)
                    OP_ENQUEUE: state_next = ST_ENQ_SCAN;
                    OP_WRITE:   state_next = ST_EMIT_FINAL;
                    OP_ACK:     state_next = ST_ACK_SCAN;
                    OP_POLL:    state_next = ST_POLL_SCAN;
                    OP_READ:    state_next = ST_READ_WAIT;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_ENQ_SCAN:
            begin
                if (!status.slot_used || status.scan_last)
                begin
                    state_next = ST_EMIT_FINAL;
                end
            end
            ST_ACK_SCAN:
            begin
                if (status.slot_used)
                begin
                    state_next = ST_ACK_META;
                end
                else if (status.scan_last)
                begin
                    state_next = ST_EMIT_FINAL;
                end
            end
            ST_ACK_META:
            begin
                if (status.seq_match || status.scan_last)
                begin
                    state_next = ST_EMIT_FINAL;
                end
                else
                begin
                    state_next = ST_ACK_SCAN;
                end
            end
            ST_POLL_SCAN:
            begin
                if (status.slot_used)
                begin
                    state_next = ST_POLL_META;
                end
                else if (status.scan_last)
                begin
                    state_next = ST_EMIT_FINAL;
                end
            end
            ST_POLL_META:
            begin
                state_next = status.entry_fits ? ST_EMIT_ENTRY : ST_EMIT_FINAL;
            end
            ST_READ_WAIT:
            begin
                state_next = ST_EMIT_FINAL;
            end
            ST_EMIT_ENTRY:
            begin
                if (status.out_free)
                begin
                    state_next = status.scan_last ? ST_EMIT_FINAL : ST_POLL_SCAN;
                end
            end
            ST_EMIT_FINAL:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready  = 1'b1;
                cmd.capture = item_valid;
            end
            ST_DISPATCH:
            begin
                cmd.data_wr = (status.op == OP_WRITE);
                cmd.data_rd = (status.op == OP_READ);
            end
            ST_ENQ_SCAN:
            begin
                cmd.enq_commit = !status.slot_used;
                cmd.scan_step  = status.slot_used && !status.scan_last;
            end
            ST_ACK_SCAN, ST_POLL_SCAN:
            begin
                cmd.meta_rd   = status.slot_used;
                cmd.scan_step = !status.slot_used && !status.scan_last;
            end
            ST_ACK_META:
            begin
                cmd.ack_commit = status.seq_match;
                cmd.scan_step  = !status.seq_match && !status.scan_last;
            end
            ST_POLL_META:
            begin
                cmd.entry_commit = status.entry_fits;
            end
            ST_READ_WAIT:
            begin
                cmd.byte_take = 1'b1;
            end
            ST_EMIT_ENTRY:
            begin
                cmd.out_load  = status.out_free;
                cmd.out_kind  = KIND_POLL_ENTRY;
                cmd.scan_step = status.out_free && !status.scan_last;
            end
            ST_EMIT_FINAL:
            begin
                cmd.out_load = status.out_free;
                cmd.out_kind = final_kind;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ hw/rtl/per_dpath.sv @@
module per_dpath
    import per_pkg::*;
#(
    parameter int RING_SLOTS      = DEF_RING_SLOTS,
    parameter int MAX_EVENT_BYTES = DEF_MAX_EVENT_BYTES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  per_cmd_t               cmd,
    output per_status_t            status,
    input  logic [OP_W-1:0]        operation,
    input  logic [TYPE_W-1:0]      event_type,
    input  logic [LEN_IN_W-1:0]    event_len,
    input  logic [BYTE_W-1:0]      data_byte,
    input  logic [IDX_W-1:0]       byte_index,
    input  logic [SEQ_W-1:0]       ack_seq,
    input  logic [SEL_W-1:0]       slot_select,
    input  logic                   cfg_wr_en,
    input  logic [BUDGET_W-1:0]    cfg_wr_data,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [KIND_W-1:0]      kind,
    output logic                   ok,
    output logic [SEQ_W-1:0]       seq_out,
    output logic [TYPE_W-1:0]      type_out,
    output logic [LEN_OUT_W-1:0]   len_out,
    output logic [SLOT_OUT_W-1:0]  slot_out,
    output logic [BYTE_W-1:0]      byte_out,
    output logic [COUNT_OUT_W-1:0] count_out,
    output logic                   last
);

    localparam int SLOT_W     = $clog2(RING_SLOTS);
    localparam int LEN_W      = $clog2(MAX_EVENT_BYTES + 1);
    localparam int CNT_W      = $clog2(RING_SLOTS + 1);
    localparam int META_W     = SEQ_W + TYPE_W + LEN_W;
    localparam int DATA_DEPTH = RING_SLOTS * MAX_EVENT_BYTES;
    localparam int DATA_AW    = $clog2(DATA_DEPTH);
    localparam int OFF_W      = BUDGET_W + 1;

    // Latched item
    logic [OP_W-1:0]     op_reg;
    logic [TYPE_W-1:0]   type_reg;
    logic [LEN_IN_W-1:0] len_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [SEQ_W-1:0]    ack_reg;
    logic [SEL_W-1:0]    sel_reg;

    // Ring state
    logic [RING_SLOTS-1:0] used_reg;
    logic [SEQ_W-1:0]      next_seq_reg;
    logic [SLOT_W-1:0]     fill_slot_reg;
    logic [BUDGET_W-1:0]   budget_reg;
    logic [SLOT_W-1:0]     scan_idx_reg;
    logic [OFF_W-1:0]      off_reg;
    logic [CNT_W-1:0]      count_reg;

    // Held result fields
    logic              res_ok_reg;
    logic [SEQ_W-1:0]  res_seq_reg;
    logic [TYPE_W-1:0] res_type_reg;
    logic [LEN_W-1:0]  res_len_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic [BYTE_W-1:0] res_byte_reg;

    // Result register
    logic                   out_valid_reg;
    logic [KIND_W-1:0]      out_kind_reg;
    logic                   out_ok_reg;
    logic [SEQ_W-1:0]       out_seq_reg;
    logic [TYPE_W-1:0]      out_type_reg;
    logic [LEN_OUT_W-1:0]   out_len_reg;
    logic [SLOT_OUT_W-1:0]  out_slot_reg;
    logic [BYTE_W-1:0]      out_byte_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;
    logic                   out_last_reg;

    logic                   out_ok_next;
    logic [SEQ_W-1:0]       out_seq_next;
    logic [TYPE_W-1:0]      out_type_next;
    logic [LEN_OUT_W-1:0]   out_len_next;
    logic [SLOT_OUT_W-1:0]  out_slot_next;
    logic [BYTE_W-1:0]      out_byte_next;
    logic [COUNT_OUT_W-1:0] out_count_next;

    logic [LEN_W-1:0]   clamped_len;
    logic [SEQ_W-1:0]   seq_inc;
    logic [META_W-1:0]  meta_wdata;
    logic [META_W-1:0]  meta_rdata;
    logic [SEQ_W-1:0]   meta_seq;
    logic [TYPE_W-1:0]  meta_type;
    logic [LEN_W-1:0]   meta_len;
    logic [OFF_W-1:0]   off_sum;
    logic               idx_ok;
    logic               sel_ok;
    logic [DATA_AW-1:0] data_waddr;
    logic [DATA_AW-1:0] data_raddr;
    logic [BYTE_W-1:0]  data_rdata;

    assign clamped_len = (int'(len_reg) > MAX_EVENT_BYTES) ? LEN_W'(MAX_EVENT_BYTES)
                                                          : LEN_W'(len_reg);
    assign seq_inc     = next_seq_reg + SEQ_W'(1);
    assign meta_wdata  = {next_seq_reg, type_reg, clamped_len};
    assign meta_seq    = meta_rdata[META_W-1 -: SEQ_W];
    assign meta_type   = meta_rdata[LEN_W +: TYPE_W];
    assign meta_len    = meta_rdata[LEN_W-1:0];
    assign off_sum     = off_reg + OFF_W'(HEADER_BYTES) + OFF_W'(meta_len);
    assign idx_ok      = int'(idx_reg) < MAX_EVENT_BYTES;
    assign sel_ok      = int'(sel_reg) < RING_SLOTS;
    assign data_waddr  = DATA_AW'(int'(fill_slot_reg) * MAX_EVENT_BYTES + int'(idx_reg));
    assign data_raddr  = DATA_AW'(int'(sel_reg) * MAX_EVENT_BYTES + int'(idx_reg));

    per_ram #(
        .WIDTH (META_W),
        .DEPTH (RING_SLOTS)
    ) u_meta_ram (
        .clk     (clk),
        .wr_en   (cmd.enq_commit),
        .wr_addr (scan_idx_reg),
        .wr_data (meta_wdata),
        .rd_en   (cmd.meta_rd),
        .rd_addr (scan_idx_reg),
        .rd_data (meta_rdata)
    );

    per_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DATA_DEPTH)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (cmd.data_wr && idx_ok),
        .wr_addr (data_waddr),
        .wr_data (byte_reg),
        .rd_en   (cmd.data_rd),
        .rd_addr (data_raddr),
        .rd_data (data_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= operation;
            type_reg <= event_type;
            len_reg  <= event_len;
            byte_reg <= data_byte;
            idx_reg  <= byte_index;
            ack_reg  <= ack_seq;
            sel_reg  <= slot_select;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            next_seq_reg  <= FIRST_SEQ;
            fill_slot_reg <= '0;
            budget_reg    <= BUDGET_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                budget_reg <= cfg_wr_data;
            end
            if (cmd.enq_commit)
            begin
                used_reg[scan_idx_reg] <= 1'b1;
                fill_slot_reg          <= scan_idx_reg;
                next_seq_reg           <= (seq_inc == '0) ? FIRST_SEQ : seq_inc;
            end
            if (cmd.ack_commit)
            begin
                used_reg[scan_idx_reg] <= 1'b0;
            end
        end
    end

    // Scan position, poll totals and held result fields
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            scan_idx_reg <= '0;
            off_reg      <= OFF_W'(1);
            count_reg    <= '0;
            res_ok_reg   <= 1'b0;
            res_seq_reg  <= '0;
            res_type_reg <= '0;
            res_len_reg  <= '0;
            res_slot_reg <= '0;
            res_byte_reg <= '0;
        end
        else
        begin
            if (cmd.scan_step)
            begin
                scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
            end
            if (cmd.enq_commit)
            begin
                res_ok_reg   <= 1'b1;
                res_seq_reg  <= next_seq_reg;
                res_len_reg  <= clamped_len;
                res_slot_reg <= scan_idx_reg;
            end
            if (cmd.ack_commit)
            begin
                res_ok_reg <= 1'b1;
            end
            if (cmd.entry_commit)
            begin
                off_reg      <= off_sum;
                count_reg    <= count_reg + CNT_W'(1);
                res_seq_reg  <= meta_seq;
                res_type_reg <= meta_type;
                res_len_reg  <= meta_len;
                res_slot_reg <= scan_idx_reg;
            end
            if (cmd.byte_take)
            begin
                res_byte_reg <= (sel_ok && idx_ok) ? data_rdata : '0;
            end
        end
    end

    // Select the fields that carry meaning for each result kind
    always_comb
    begin
        out_ok_next    = 1'b0;
        out_seq_next   = '0;
        out_type_next  = '0;
        out_len_next   = '0;
        out_slot_next  = '0;
        out_byte_next  = '0;
        out_count_next = '0;
        case (cmd.out_kind)
            KIND_ENQ_REPLY:
            begin
                out_ok_next   = res_ok_reg;
                out_seq_next  = res_seq_reg;
                out_len_next  = LEN_OUT_W'(res_len_reg);
                out_slot_next = SLOT_OUT_W'(res_slot_reg);
            end
            KIND_ACK_REPLY:
            begin
                out_ok_next = res_ok_reg;
            end
            KIND_POLL_ENTRY:
            begin
                out_seq_next  = res_seq_reg;
                out_type_next = res_type_reg;
                out_len_next  = LEN_OUT_W'(res_len_reg);
                out_slot_next = SLOT_OUT_W'(res_slot_reg);
            end
            KIND_POLL_SUMMARY:
            begin
                out_count_next = COUNT_OUT_W'(count_reg);
            end
            KIND_READ_BYTE:
            begin
                out_byte_next = res_byte_reg;
            end
            default:
            begin
                out_ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_kind_reg  <= cmd.out_kind;
            out_ok_reg    <= out_ok_next;
            out_seq_reg   <= out_seq_next;
            out_type_reg  <= out_type_next;
            out_len_reg   <= out_len_next;
            out_slot_reg  <= out_slot_next;
            out_byte_reg  <= out_byte_next;
            out_count_reg <= out_count_next;
            out_last_reg  <= (cmd.out_kind != KIND_POLL_ENTRY);
        end
    end

    assign status.op         = op_reg;
    assign status.slot_used  = used_reg[scan_idx_reg];
    assign status.scan_last  = (scan_idx_reg == SLOT_W'(RING_SLOTS - 1));
    assign status.seq_match  = (meta_seq == ack_reg);
    assign status.entry_fits = (off_sum <= OFF_W'(budget_reg));
    assign status.out_free   = !out_valid_reg || result_ready;

    assign result_valid = out_valid_reg;
    assign kind         = out_kind_reg;
    assign ok           = out_ok_reg;
    assign seq_out      = out_seq_reg;
    assign type_out     = out_type_reg;
    assign len_out      = out_len_reg;
    assign slot_out     = out_slot_reg;
    assign byte_out     = out_byte_reg;
    assign count_out    = out_count_reg;
    assign last         = out_last_reg;

endmodule

@@ hw/rtl/pending_event_ring.sv @@
// Channel   | Handshake                 | Payload
// ----------+---------------------------+-----------------------------------------------
// item      | item_valid / item_ready   | operation, event_type, event_len, data_byte,
//           |                           | byte_index, ack_seq, slot_select
// result    | result_valid/result_ready | kind, ok, seq_out, type_out, len_out, slot_out,
//           |                           | byte_out, count_out, last
// config    | cfg_wr_en (no wait)       | cfg_wr_data -> poll_budget
//
// Sequencing: one transaction at a time, item_ready only while idle. An enqueue walks the
// used marks one slot a cycle up to the lowest free slot. Ack and poll walk the slots and
// read the header of each used one; a poll also emits one entry per slot listed, and each
// entry waits for the result register to be free before the walk goes on.
// Reset clears the used marks, sets the sequence counter to 1 and the budget to 255 and
// leaves the memories as they are. A stalled result holds the controller in its emit state.
module pending_event_ring
    import per_pkg::*;
#(
    parameter int RING_SLOTS      = DEF_RING_SLOTS,
    parameter int MAX_EVENT_BYTES = DEF_MAX_EVENT_BYTES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // Item channel
    input  logic                   item_valid,
    output logic                   item_ready,
    input  logic [OP_W-1:0]        operation,
    input  logic [TYPE_W-1:0]      event_type,
    input  logic [LEN_IN_W-1:0]    event_len,
    input  logic [BYTE_W-1:0]      data_byte,
    input  logic [IDX_W-1:0]       byte_index,
    input  logic [SEQ_W-1:0]       ack_seq,
    input  logic [SEL_W-1:0]       slot_select,
    // Poll budget register
    input  logic                   cfg_wr_en,
    input  logic [BUDGET_W-1:0]    cfg_wr_data,
    // Result channel
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [KIND_W-1:0]      kind,
    output logic                   ok,
    output logic [SEQ_W-1:0]       seq_out,
    output logic [TYPE_W-1:0]      type_out,
    output logic [LEN_OUT_W-1:0]   len_out,
    output logic [SLOT_OUT_W-1:0]  slot_out,
    output logic [BYTE_W-1:0]      byte_out,
    output logic [COUNT_OUT_W-1:0] count_out,
    output logic                   last
);

    per_cmd_t    cmd;
    per_status_t status;

    // Sequencer: decodes the operation, walks the slots and paces the results
    per_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Ring storage, poll accounting and the result register
    per_dpath #(
        .RING_SLOTS      (RING_SLOTS),
        .MAX_EVENT_BYTES (MAX_EVENT_BYTES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .operation    (operation),
        .event_type   (event_type),
        .event_len    (event_len),
        .data_byte    (data_byte),
        .byte_index   (byte_index),
        .ack_seq      (ack_seq),
        .slot_select  (slot_select),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .ok           (ok),
        .seq_out      (seq_out),
        .type_out     (type_out),
        .len_out      (len_out),
        .slot_out     (slot_out),
        .byte_out     (byte_out),
        .count_out    (count_out),
        .last         (last)
    );

    // A result is loaded only when the result register is free or being drained
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result register overwritten while a result waits");

    // At most one storage update in any cycle
    a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.enq_commit, cmd.ack_commit, cmd.entry_commit,
                  cmd.data_wr, cmd.data_rd}))
        else $error("conflicting storage commands");

    // An ack frees only a slot that is in use
    a_ack_used: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ack_commit |-> status.slot_used)
        else $error("ack freed a slot that was not in use");

    // No new transaction while the previous item is still being worked
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready)
        else $error("item accepted during work on another");

endmodule
